// ===== src/afm_pkg.sv =====
package afm_pkg;

   localparam int FILTER_SHIFT_DEF = 8;
   localparam int SAMPLE_BITS_DEF  = 10;

   localparam int GAIN_W = 16;
   localparam int MEAS_W = 16;
   localparam int CH_W   = 2;
   localparam int NUM_CH = 4;

   localparam logic [CH_W-1:0] CH_GROUND  = 2'd0;
   localparam logic [CH_W-1:0] CH_CURRENT = 2'd1;
   localparam logic [CH_W-1:0] CH_VOLTAGE = 2'd2;
   localparam logic [CH_W-1:0] CH_TEMP    = 2'd3;

   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_GAIN = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_CURRENT_GAIN = 2'd1;

   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int RECIP_W = 29;
   // floor(x / 1000) = (x * ceil(2^38 / 1000)) >> 38 for any 32-bit x
   localparam logic [RECIP_W-1:0] SCALE_RECIP = 29'd274877907;
   localparam int RECIP_SHIFT = 38;

   localparam int SAT_W = MUL_W + 1;
   localparam logic [SAT_W-1:0]  SAT_LIMIT = 33'd65535000;
   localparam logic [MEAS_W-1:0] SAT_VALUE = 16'hFFFF;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [GAIN_W-1:0] voltage_gain;
      logic [GAIN_W-1:0] current_gain;
   } gain_type;

endpackage

// ===== src/afm_front.sv =====
module afm_front #(
   parameter int FILTER_SHIFT = afm_pkg::FILTER_SHIFT_DEF,
   parameter int SAMPLE_BITS  = afm_pkg::SAMPLE_BITS_DEF,
   parameter int ENTRY_W      = 3 * SAMPLE_BITS + afm_pkg::CH_W + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_code,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [ENTRY_W-1:0]     out_entry
);

   localparam int ACC_W = SAMPLE_BITS + FILTER_SHIFT;
   localparam logic [ACC_W:0] ROUND = (ACC_W + 1)'(1) << (FILTER_SHIFT - 1);

   logic [ACC_W-1:0]          acc_ff  [afm_pkg::NUM_CH];
   logic [SAMPLE_BITS-1:0]    filt_ff [afm_pkg::NUM_CH];
   logic [afm_pkg::CH_W-1:0]  chan_ff;
   logic [afm_pkg::CH_W-1:0]  chan_in;

   logic [ACC_W-1:0]       acc_cur;
   logic [ACC_W:0]         acc_round;
   logic [SAMPLE_BITS:0]   filt_wide;
   logic [SAMPLE_BITS-1:0] filt;
   logic [ACC_W-1:0]       acc_in;
   logic [SAMPLE_BITS-1:0] icode;
   logic [SAMPLE_BITS-1:0] vcode;
   logic                   done;
   logic                   fire;

   assign in_ready  = out_ready;
   assign out_valid = in_valid;
   assign fire      = in_valid && out_ready;

   always_comb begin
      acc_cur   = acc_ff[chan_ff];
      acc_round = {1'b0, acc_cur} + ROUND;
      filt_wide = acc_round[ACC_W:FILTER_SHIFT];
      filt      = filt_wide[SAMPLE_BITS] ? '1 : filt_wide[SAMPLE_BITS-1:0];
      acc_in    = acc_cur + ACC_W'(in_code) - ACC_W'(filt);
      chan_in   = chan_ff + afm_pkg::CH_W'(1);
      done      = (chan_ff == afm_pkg::CH_TEMP);
      // ground offset removed, floored at zero
      icode = (filt_ff[afm_pkg::CH_GROUND] > filt_ff[afm_pkg::CH_CURRENT]) ? '0 :
              filt_ff[afm_pkg::CH_CURRENT] - filt_ff[afm_pkg::CH_GROUND];
      vcode = (filt_ff[afm_pkg::CH_GROUND] > filt_ff[afm_pkg::CH_VOLTAGE]) ? '0 :
              filt_ff[afm_pkg::CH_VOLTAGE] - filt_ff[afm_pkg::CH_GROUND];
      out_entry = {vcode, icode, done, filt, chan_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
         for (int i = 0; i < afm_pkg::NUM_CH; i++) begin
            acc_ff[i]  <= '0;
            filt_ff[i] <= '0;
         end
      end else if (fire) begin
         chan_ff          <= chan_in;
         acc_ff[chan_ff]  <= acc_in;
         filt_ff[chan_ff] <= filt;
      end
   end

endmodule

// ===== src/afm_queue.sv =====
module afm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = afm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != FULL);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== src/afm_back.sv =====
module afm_back #(
   parameter int SAMPLE_BITS = afm_pkg::SAMPLE_BITS_DEF,
   parameter int ENTRY_W     = 3 * SAMPLE_BITS + afm_pkg::CH_W + 1,
   parameter int RSP_W       = ((2 * SAMPLE_BITS + 3 * afm_pkg::MEAS_W + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  afm_pkg::gain_type         gains,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [ENTRY_W-1:0]        in_entry,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [RSP_W-1:0]          out_data,
   output logic [afm_pkg::CH_W-1:0]  out_user,
   output logic                      out_last
);

   localparam int MW = afm_pkg::MEAS_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_VMUL, ST_VDIV, ST_IMUL, ST_IDIV, ST_PSEL, ST_PMUL, ST_PDIV, ST_DONE
   } state_type;

   state_type state_ff;

   logic [afm_pkg::CH_W-1:0] e_ch;
   logic [SAMPLE_BITS-1:0]   e_filt;
   logic                     e_done;
   logic [SAMPLE_BITS-1:0]   e_icode;
   logic [SAMPLE_BITS-1:0]   e_vcode;

   logic [afm_pkg::CH_W-1:0] w_ch_ff;
   logic [SAMPLE_BITS-1:0]   w_filt_ff;
   logic [SAMPLE_BITS-1:0]   w_icode_ff;
   logic [SAMPLE_BITS-1:0]   w_vcode_ff;
   logic [MW-1:0]            volt_ff;
   logic [MW-1:0]            curr_ff;
   logic                     sat_ff;
   logic [afm_pkg::PROD_W-1:0] prod_ff;

   logic                     out_valid_ff;
   logic [afm_pkg::CH_W-1:0] out_ch_ff;
   logic [SAMPLE_BITS-1:0]   out_filt_ff;
   logic                     out_last_ff;
   logic [MW-1:0]            out_volt_ff;
   logic [MW-1:0]            out_curr_ff;
   logic [MW-1:0]            out_pow_ff;
   logic [SAMPLE_BITS-1:0]   out_temp_ff;

   logic [afm_pkg::MUL_W-1:0]  mul_a;
   logic [afm_pkg::MUL_W-1:0]  mul_b;
   logic [afm_pkg::GAIN_W-1:0] sat_gain;
   logic                       sat;
   logic [MW-1:0]              quot;
   logic                       out_free;
   logic                       out_load;

   assign {e_vcode, e_icode, e_done, e_filt, e_ch} = in_entry;

   assign out_free  = !out_valid_ff || out_ready;
   assign in_ready  = (state_ff == ST_IDLE) && out_free;
   assign out_load  = ((state_ff == ST_IDLE) && in_valid && out_free && !e_done) ||
                      ((state_ff == ST_DONE) && out_free);
   assign quot      = prod_ff[afm_pkg::RECIP_SHIFT +: MW];
   assign out_valid = out_valid_ff;
   assign out_user  = out_ch_ff;
   assign out_last  = out_last_ff;
   assign out_data  = RSP_W'({out_temp_ff, out_pow_ff, out_curr_ff, out_volt_ff, out_filt_ff});

   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      sat_gain = gains.voltage_gain;
      unique case (state_ff)
         ST_VMUL: begin
            mul_a = afm_pkg::MUL_W'(w_vcode_ff);
            mul_b = afm_pkg::MUL_W'(gains.voltage_gain);
         end
         ST_IMUL: begin
            mul_a = afm_pkg::MUL_W'(w_icode_ff);
            mul_b = afm_pkg::MUL_W'(gains.current_gain);
         end
         ST_PMUL: begin
            mul_a = afm_pkg::MUL_W'(volt_ff);
            mul_b = afm_pkg::MUL_W'(curr_ff);
         end
         ST_VDIV, ST_IDIV, ST_PDIV: begin
            mul_a = prod_ff[afm_pkg::MUL_W-1:0];
            mul_b = afm_pkg::MUL_W'(afm_pkg::SCALE_RECIP);
            if (state_ff == ST_IDIV) begin
               sat_gain = gains.current_gain;
            end
         end
         default: begin
         end
      endcase
      // (code + 1) * gain above the limit, or no gain set
      sat = (sat_gain == '0) ||
            (({1'b0, prod_ff[afm_pkg::MUL_W-1:0]} + afm_pkg::SAT_W'(sat_gain))
             > afm_pkg::SAT_LIMIT);
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_ready && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid && out_free) begin
                  w_ch_ff    <= e_ch;
                  w_filt_ff  <= e_filt;
                  w_icode_ff <= e_icode;
                  w_vcode_ff <= e_vcode;
                  if (e_done) begin
                     state_ff <= ST_VMUL;
                  end else begin
                     out_valid_ff <= 1'b1;
                     out_ch_ff    <= e_ch;
                     out_filt_ff  <= e_filt;
                     out_last_ff  <= 1'b0;
                     out_volt_ff  <= '0;
                     out_curr_ff  <= '0;
                     out_pow_ff   <= '0;
                     out_temp_ff  <= '0;
                  end
               end
            end
            ST_VMUL: state_ff <= ST_VDIV;
            ST_VDIV: begin
               sat_ff   <= sat;
               state_ff <= ST_IMUL;
            end
            ST_IMUL: begin
               volt_ff  <= sat_ff ? afm_pkg::SAT_VALUE : quot;
               state_ff <= ST_IDIV;
            end
            ST_IDIV: begin
               sat_ff   <= sat;
               state_ff <= ST_PSEL;
            end
            ST_PSEL: begin
               curr_ff  <= sat_ff ? afm_pkg::SAT_VALUE : quot;
               state_ff <= ST_PMUL;
            end
            ST_PMUL: state_ff <= ST_PDIV;
            ST_PDIV: state_ff <= ST_DONE;
            ST_DONE: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_ch_ff    <= w_ch_ff;
                  out_filt_ff  <= w_filt_ff;
                  out_last_ff  <= 1'b1;
                  out_volt_ff  <= volt_ff;
                  out_curr_ff  <= curr_ff;
                  out_pow_ff   <= quot;
                  out_temp_ff  <= w_filt_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== src/adc_filter_measure_core.sv =====
// the result word for channels 0..2 is registered at the output after passing the queue; the
//    temperature word, which closes the frame, first runs VMUL, VDIV, IMUL, IDIV, PSEL, PMUL, PDIV, DONE
// throughput: one word a cycle into the 4-entry queue while it has room; the back end takes
//    filter-only words while its output is free and no new word while the temperature word is on the shared multiplier
// reset: synchronous, clears channel counter, filters, gains, queue and output
module adc_filter_measure_core #(
   parameter int FILTER_SHIFT = afm_pkg::FILTER_SHIFT_DEF,
   parameter int SAMPLE_BITS  = afm_pkg::SAMPLE_BITS_DEF,
   parameter int REQ_W        = ((SAMPLE_BITS + 7) / 8) * 8,
   parameter int RSP_W        = ((2 * SAMPLE_BITS + 3 * afm_pkg::MEAS_W + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sample_code
   input  logic [REQ_W-1:0]                req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // filtered_code, volt_reading, curr_reading, power_reading, temperature_code
   output logic [RSP_W-1:0]                rsp_tdata,
   // channel_index
   output logic [afm_pkg::CH_W-1:0]        rsp_tuser,
   // frame_done
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [afm_pkg::REG_IDX_W-1:0]   csr_index,
   input  logic [afm_pkg::GAIN_W-1:0]      csr_wdata
);

   localparam int ENTRY_W = 3 * SAMPLE_BITS + afm_pkg::CH_W + 1;

   afm_pkg::gain_type gain_ff;

   logic               fq_valid;
   logic               fq_ready;
   logic [ENTRY_W-1:0] fq_entry;
   logic               qb_valid;
   logic               qb_ready;
   logic [ENTRY_W-1:0] qb_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            afm_pkg::REG_VOLTAGE_GAIN: gain_ff.voltage_gain <= csr_wdata;
            afm_pkg::REG_CURRENT_GAIN: gain_ff.current_gain <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   afm_front #(
      .FILTER_SHIFT (FILTER_SHIFT),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .ENTRY_W      (ENTRY_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_code   (req_tdata[SAMPLE_BITS-1:0]),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_entry (fq_entry)
   );

   afm_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (afm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_entry),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_entry)
   );

   afm_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ENTRY_W     (ENTRY_W),
      .RSP_W       (RSP_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .gains     (gain_ff),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_entry  (qb_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== src/afm_checker.sv =====
module afm_checker #(
   parameter int SAMPLE_BITS = afm_pkg::SAMPLE_BITS_DEF,
   parameter int RSP_W       = ((2 * SAMPLE_BITS + 3 * afm_pkg::MEAS_W + 7) / 8) * 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_W-1:0]         rsp_tdata,
   input logic [afm_pkg::CH_W-1:0] rsp_tuser,
   input logic                     rsp_tlast
);

   localparam int MEAS_LO = SAMPLE_BITS;
   localparam int MEAS_N  = 3 * afm_pkg::MEAS_W + SAMPLE_BITS;

   logic [MEAS_N-1:0] meas;
   assign meas = rsp_tdata[MEAS_LO +: MEAS_N];

   a_last_on_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == afm_pkg::CH_TEMP)))
      else $error("frame end not on temperature channel");

   a_meas_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (meas == '0))
      else $error("measurements set outside frame end");

   a_temp_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
      (rsp_tdata[SAMPLE_BITS-1:0] == rsp_tdata[MEAS_LO + 3 * afm_pkg::MEAS_W +: SAMPLE_BITS]))
      else $error("temperature code differs from filtered code");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response word changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind adc_filter_measure_core afm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS),
   .RSP_W       (RSP_W)
) u_afm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/tb_adc_filter_measure_core.sv =====
`timescale 1ns / 100ps

module tb_adc_filter_measure_core;

   localparam int FILTER_SHIFT = afm_pkg::FILTER_SHIFT_DEF;
   localparam int SAMPLE_BITS  = afm_pkg::SAMPLE_BITS_DEF;
   localparam int ACC_W        = SAMPLE_BITS + FILTER_SHIFT;
   localparam int MEAS_W       = afm_pkg::MEAS_W;
   localparam int CH_W         = afm_pkg::CH_W;
   localparam int GAIN_W       = afm_pkg::GAIN_W;
   localparam int REG_IDX_W    = afm_pkg::REG_IDX_W;
   localparam int REQ_W        = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_W        = ((2 * SAMPLE_BITS + 3 * MEAS_W + 7) / 8) * 8;

   localparam int VOLT_LSB = SAMPLE_BITS;
   localparam int CURR_LSB = VOLT_LSB + MEAS_W;
   localparam int PWR_LSB  = CURR_LSB + MEAS_W;
   localparam int TEMP_LSB = PWR_LSB + MEAS_W;

   localparam longint unsigned SCALE_DIV      = 1000;
   localparam longint unsigned SAT_CODE_LIMIT = 65535000;
   localparam logic [SAMPLE_BITS-1:0] CODE_MAX = '1;

   localparam int DIR_ROWS    = 20;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_ITEMS = 141;
   localparam int HOLD_CYCLES = 300;
   localparam int END_CYCLES  = 20;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [CH_W-1:0]        chan;
      logic [SAMPLE_BITS-1:0] filt;
      logic                   done;
      logic [MEAS_W-1:0]      volt;
      logic [MEAS_W-1:0]      curr;
      logic [MEAS_W-1:0]      pwr;
      logic [SAMPLE_BITS-1:0] temp;
   } meas_word_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] code;
      logic                   fixed;
      meas_word_type          want;
   } dir_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   // sample_code
   logic [REQ_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // filtered_code, volt_reading, curr_reading, power_reading, temperature_code
   logic [RSP_W-1:0]     rsp_tdata;
   // channel_index
   logic [CH_W-1:0]      rsp_tuser;
   // frame_done
   logic                 rsp_tlast;
   logic                 csr_we;
   logic [REG_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wdata;

   logic [CH_W-1:0]        next_chan;
   logic [ACC_W-1:0]       chan_acc [afm_pkg::NUM_CH];
   logic [SAMPLE_BITS-1:0] chan_filt [afm_pkg::NUM_CH];
   logic [GAIN_W-1:0]      volt_gain;
   logic [GAIN_W-1:0]      curr_gain;

   meas_word_type meas_due [$];
   dir_row_type   dir_table [DIR_ROWS];
   int            mismatches;
   int            cycles;
   bit            idle_on;
   bit            hold_req;

   adc_filter_measure_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [MEAS_W-1:0] scale_meas(longint unsigned code,
                                                   longint unsigned gain);
      if (gain == 0 || (code + 1) * gain > SAT_CODE_LIMIT)
         return afm_pkg::SAT_VALUE;
      return MEAS_W'((code * gain) / SCALE_DIV);
   endfunction

   function automatic meas_word_type predict_meas(logic [SAMPLE_BITS-1:0] code);
      meas_word_type w;
      logic [CH_W-1:0] ch;
      longint unsigned rounded, gnd, icode, vcode, v, i;
      ch = next_chan;
      rounded = chan_acc[ch];
      rounded = (rounded + (1 << (FILTER_SHIFT - 1))) >> FILTER_SHIFT;
      if (rounded > CODE_MAX)
         rounded = CODE_MAX;
      chan_acc[ch] = ACC_W'(chan_acc[ch] + code - rounded);
      chan_filt[ch] = SAMPLE_BITS'(rounded);
      next_chan = next_chan + CH_W'(1);
      w = '0;
      w.chan = ch;
      w.filt = SAMPLE_BITS'(rounded);
      w.done = (ch == afm_pkg::CH_TEMP);
      if (w.done) begin
         gnd = chan_filt[afm_pkg::CH_GROUND];
         icode = chan_filt[afm_pkg::CH_CURRENT];
         vcode = chan_filt[afm_pkg::CH_VOLTAGE];
         // ground offset removed, floored at zero
         icode = (gnd > icode) ? 0 : icode - gnd;
         vcode = (gnd > vcode) ? 0 : vcode - gnd;
         v = scale_meas(vcode, volt_gain);
         i = scale_meas(icode, curr_gain);
         w.volt = MEAS_W'(v);
         w.curr = MEAS_W'(i);
         w.pwr = MEAS_W'((v * i) / SCALE_DIV);
         w.temp = chan_filt[afm_pkg::CH_TEMP];
      end
      return w;
   endfunction

   // well-formed frames: low ground, high current and voltage; the rest is noise
   function automatic logic [SAMPLE_BITS-1:0] draw_code(logic [CH_W-1:0] ch);
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return CODE_MAX;
      if (pick < 5)
         return SAMPLE_BITS'($urandom_range(0, CODE_MAX));
      case (ch)
         afm_pkg::CH_GROUND: return SAMPLE_BITS'($urandom_range(0, 48));
         afm_pkg::CH_CURRENT, afm_pkg::CH_VOLTAGE:
            return SAMPLE_BITS'($urandom_range(384, CODE_MAX));
         default: return SAMPLE_BITS'($urandom_range(0, CODE_MAX));
      endcase
   endfunction

   task automatic write_gain(logic [REG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         afm_pkg::REG_VOLTAGE_GAIN: volt_gain = val;
         afm_pkg::REG_CURRENT_GAIN: curr_gain = val;
         default: ;
      endcase
   endtask

   task automatic send_sample(logic [SAMPLE_BITS-1:0] code, logic fixed,
                              meas_word_type want);
      int gap;
      meas_word_type pred;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'(code);
      do @(posedge clock); while (req_tready !== 1'b1);
      pred = predict_meas(code);
      meas_due.push_back(fixed ? want : pred);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (meas_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_word();
      meas_word_type want;
      meas_word_type got;
      got.chan = rsp_tuser;
      got.filt = rsp_tdata[0 +: SAMPLE_BITS];
      got.done = rsp_tlast;
      got.volt = rsp_tdata[VOLT_LSB +: MEAS_W];
      got.curr = rsp_tdata[CURR_LSB +: MEAS_W];
      got.pwr  = rsp_tdata[PWR_LSB +: MEAS_W];
      got.temp = rsp_tdata[TEMP_LSB +: SAMPLE_BITS];
      if (meas_due.size() == 0) begin
         $error("result word with nothing expected");
         mismatches++;
      end else begin
         want = meas_due.pop_front();
         if (got != want)
            mismatches++;
         if (got.chan != want.chan)
            $error("channel_index: expected %0d, got %0d", want.chan, got.chan);
         if (got.filt != want.filt)
            $error("filtered_code: expected %0d, got %0d", want.filt, got.filt);
         if (got.done != want.done)
            $error("frame_done: expected %0d, got %0d", want.done, got.done);
         if (got.volt != want.volt)
            $error("volt_reading: expected %0d, got %0d", want.volt, got.volt);
         if (got.curr != want.curr)
            $error("curr_reading: expected %0d, got %0d", want.curr, got.curr);
         if (got.pwr != want.pwr)
            $error("power_reading: expected %0d, got %0d", want.pwr, got.pwr);
         if (got.temp != want.temp)
            $error("temperature_code: expected %0d, got %0d", want.temp, got.temp);
      end
   endtask

   // result side
   initial begin
      int gap;
      wait (reset === 1'b0);
      forever begin
         gap = idle_on ? $urandom_range(0, 19) : 0;
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         check_word();
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [GAIN_W-1:0] vg, cg;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      idle_on = 1'b1;
      hold_req = 1'b0;
      next_chan = afm_pkg::CH_GROUND;
      volt_gain = '0;
      curr_gain = '0;
      foreach (chan_acc[k]) begin
         chan_acc[k] = '0;
         chan_filt[k] = '0;
      end

      // first frame after reset with zero gains: all filters at zero, both channels saturate
      dir_table = '{
         '{10'd1023, 1'b1, '{afm_pkg::CH_GROUND,  10'd0, 1'b0, 16'd0, 16'd0, 16'd0, 10'd0}},
         '{10'd0,    1'b1, '{afm_pkg::CH_CURRENT, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0, 10'd0}},
         '{10'd0,    1'b1, '{afm_pkg::CH_VOLTAGE, 10'd0, 1'b0, 16'd0, 16'd0, 16'd0, 10'd0}},
         '{10'd1023, 1'b1, '{afm_pkg::CH_TEMP, 10'd0, 1'b1, afm_pkg::SAT_VALUE,
                             afm_pkg::SAT_VALUE, 16'd34996, 10'd0}},
         '{10'd1023, 1'b0, '0}, '{10'd0, 1'b0, '0}, '{10'd0, 1'b0, '0},
         '{10'd1023, 1'b0, '0},
         '{10'd1023, 1'b0, '0}, '{10'd0, 1'b0, '0}, '{10'd1, 1'b0, '0},
         '{10'd512, 1'b0, '0},
         '{10'd1023, 1'b0, '0}, '{10'd0, 1'b0, '0}, '{10'd0, 1'b0, '0},
         '{10'd0, 1'b0, '0},
         '{10'd1023, 1'b0, '0}, '{10'd1, 1'b0, '0}, '{10'd0, 1'b0, '0},
         '{10'd1023, 1'b0, '0}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++)
         send_sample(dir_table[r].code, dir_table[r].fixed, dir_table[r].want);
      drain_results();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin vg = 16'hFFFF; cg = 16'hFFFF; end
            1: begin vg = 16'd1;    cg = 16'd1;    end
            2: begin vg = 16'd0;    cg = 16'hFFFF; end
            3: begin vg = 16'hFFFF; cg = 16'd0;    end
            4: begin vg = 16'd1000; cg = 16'd1000; end
            default: begin
               vg = GAIN_W'($urandom_range(1, 65535));
               cg = GAIN_W'($urandom_range(1, 65535));
            end
         endcase
         write_gain(afm_pkg::REG_VOLTAGE_GAIN, vg);
         write_gain(afm_pkg::REG_CURRENT_GAIN, cg);
         idle_on = (p != 1 && p != 5);
         // long receiver stall while the sender keeps going
         if (p == 1)
            hold_req = 1'b1;
         repeat (PHASE_ITEMS) send_sample(draw_code(next_chan), 1'b0, '0);
         drain_results();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
